/* sv/mpfd_pkg.sv */
// Shared types, constants and codes for the monochrome page frame buffer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mpfd_pkg;

    // Screen geometry. Each store byte holds eight vertical pixels of one column.
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);

    // A span or glyph row covers at most this many columns.
    localparam int SPAN_MAX  = 16;
    localparam int COL_IDX_W = $clog2(SPAN_MAX);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [4:0] GLYPH_W_RESET = 5'd7;
    localparam logic [4:0] GLYPH_H_RESET = 5'd10;
    localparam logic [4:0] CFG_SAT       = 5'd16;

    typedef enum logic [1:0] {
        REG_INVERT  = 2'd0,
        REG_GLYPH_W = 2'd1,
        REG_GLYPH_H = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        MODE_PIXEL  = 3'd0,
        MODE_FILL   = 3'd1,
        MODE_SPAN   = 3'd2,
        MODE_GLYPH  = 3'd3,
        MODE_CURSOR = 3'd4,
        MODE_READ   = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_DRAW = 2'd1,
        OP_FILL = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef struct packed {
        logic       invert;
        logic [4:0] glyph_width;
        logic [4:0] glyph_height;
    } t_cfg;

    // One classified item. Bit i of wen and wval belongs to column addr + i.
    typedef struct packed {
        t_op                   op;
        logic [ADDR_W-1:0]     addr;
        logic [COL_IDX_W-1:0]  last_col;
        logic [SPAN_MAX-1:0]   wen;
        logic [SPAN_MAX-1:0]   wval;
        logic [2:0]            bitsel;
        logic                  status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

/* sv/mpfd_regs.sv */
// Configuration registers behind the APB-style port.
// Depends on mpfd_pkg.
`default_nettype none

module mpfd_regs (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_psel,
    input  wire                           i_penable,
    input  wire                           i_pwrite,
    input  wire [mpfd_pkg::PADDR_W-1:0]   i_paddr,
    input  wire [mpfd_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [mpfd_pkg::PDATA_W-1:0]  o_prdata,
    output logic                          o_pready,
    output mpfd_pkg::t_cfg                o_cfg
);
    import mpfd_pkg::*;

    logic       r_invert;
    logic [4:0] r_glyph_w;
    logic [4:0] r_glyph_h;
    logic       w_wr;
    logic [4:0] w_sat;
    t_reg       w_idx;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_idx    = t_reg'(i_paddr[PADDR_W-1:2]);
    // Glyph sizes above sixteen are held at sixteen.
    assign w_sat    = (i_pwdata[4:0] > CFG_SAT) ? CFG_SAT : i_pwdata[4:0];
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert  <= 1'b0;
            r_glyph_w <= GLYPH_W_RESET;
            r_glyph_h <= GLYPH_H_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_INVERT:  r_invert  <= i_pwdata[0];
                REG_GLYPH_W: r_glyph_w <= w_sat;
                REG_GLYPH_H: r_glyph_h <= w_sat;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_INVERT:  o_prdata = PDATA_W'(r_invert);
            REG_GLYPH_W: o_prdata = PDATA_W'(r_glyph_w);
            REG_GLYPH_H: o_prdata = PDATA_W'(r_glyph_h);
            default:     o_prdata = '0;
        endcase
    end

    assign o_cfg = '{invert: r_invert, glyph_width: r_glyph_w, glyph_height: r_glyph_h};

endmodule

`default_nettype wire

/* sv/mpfd_front.sv */
// Front end: accepts items, keeps the text cursor and turns each item into a command.
// Depends on mpfd_pkg.
`default_nettype none

module mpfd_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mpfd_pkg::t_cfg       i_cfg,
    input  mpfd_pkg::t_qstat     i_qstat,
    input  wire                  i_clearing,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire [2:0]            i_mode,
    input  wire [7:0]            i_xpos,
    input  wire [7:0]            i_ypos,
    input  wire                  i_color,
    input  wire [15:0]           i_pattern,
    input  wire [4:0]            i_span_count,
    input  wire [3:0]            i_glyph_row,
    input  wire                  i_last,
    output logic                 o_push,
    output mpfd_pkg::t_cmd       o_cmd
);
    import mpfd_pkg::*;

    logic [7:0]          r_cur_col;
    logic [7:0]          r_cur_row;
    logic [7:0]          n_cur_col;
    logic [7:0]          n_cur_row;
    logic                w_x_ok;
    logic                w_y_ok;
    logic [SPAN_MAX-1:0] w_span_wen;
    logic                w_span_bad;
    logic [SPAN_MAX-1:0] w_glyph_wen;
    logic [SPAN_MAX-1:0] w_glyph_val;
    logic [8:0]          w_glyph_y;
    logic                w_glyph_fit;
    logic                w_pix_color;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [9:0] col, input logic [8:0] row);
        return ADDR_W'(32'(col) + 32'(row >> 3) * SCREEN_WIDTH);
    endfunction

    assign o_in_ready = !i_qstat.full && !i_clearing;
    assign o_push     = i_in_valid && o_in_ready;

    assign w_x_ok      = 10'(i_xpos) < 10'(SCREEN_WIDTH);
    assign w_y_ok      = 10'(i_ypos) < 10'(SCREEN_HEIGHT);
    assign w_pix_color = i_color ^ i_cfg.invert;
    assign w_glyph_y   = 9'(r_cur_row) + 9'(i_glyph_row);
    assign w_glyph_fit = (10'(r_cur_col) + 10'(i_cfg.glyph_width) < 10'(SCREEN_WIDTH))
                      && (10'(r_cur_row) + 10'(i_cfg.glyph_height) < 10'(SCREEN_HEIGHT))
                      && (5'(i_glyph_row) < i_cfg.glyph_height);

    // Per-column decode of spans and glyph rows; the columns are independent.
    always_comb begin
        w_span_bad = 1'b0;
        for (int i = 0; i < SPAN_MAX; i++) begin
            w_span_wen[i]  = i_pattern[SPAN_MAX-1-i] && (5'(i) < i_span_count)
                          && (10'(i_xpos) + 10'(i) < 10'(SCREEN_WIDTH)) && w_y_ok;
            w_span_bad     = w_span_bad || (i_pattern[SPAN_MAX-1-i] && (5'(i) < i_span_count)
                          && !w_span_wen[i]);
            w_glyph_wen[i] = 5'(i) < i_cfg.glyph_width;
            w_glyph_val[i] = (i_pattern[SPAN_MAX-1-i] ? i_color : !i_color) ^ i_cfg.invert;
        end
    end

    always_comb begin
        o_cmd     = '0;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        case (i_mode)
            MODE_PIXEL: begin
                if (w_x_ok && w_y_ok) begin
                    o_cmd.op      = OP_DRAW;
                    o_cmd.addr    = f_addr(10'(i_xpos), 9'(i_ypos));
                    o_cmd.wen[0]  = 1'b1;
                    o_cmd.wval[0] = w_pix_color;
                    o_cmd.bitsel  = i_ypos[2:0];
                end else begin
                    o_cmd.status = 1'b1;
                end
            end
            MODE_FILL: begin
                o_cmd.op      = OP_FILL;
                o_cmd.wval[0] = i_color;
            end
            MODE_SPAN: begin
                o_cmd.op       = OP_DRAW;
                o_cmd.addr     = f_addr(10'(i_xpos), 9'(i_ypos));
                o_cmd.last_col = COL_IDX_W'(SPAN_MAX - 1);
                o_cmd.wen      = w_span_wen;
                o_cmd.wval     = {SPAN_MAX{w_pix_color}};
                o_cmd.bitsel   = i_ypos[2:0];
                o_cmd.status   = w_span_bad;
            end
            MODE_GLYPH: begin
                if (w_glyph_fit) begin
                    o_cmd.op       = OP_DRAW;
                    o_cmd.addr     = f_addr(10'(r_cur_col), w_glyph_y);
                    o_cmd.last_col = COL_IDX_W'(i_cfg.glyph_width - 5'd1);
                    o_cmd.wen      = w_glyph_wen;
                    o_cmd.wval     = w_glyph_val;
                    o_cmd.bitsel   = w_glyph_y[2:0];
                    if (i_last) begin
                        n_cur_col = 8'(10'(r_cur_col) + 10'(i_cfg.glyph_width));
                    end
                end else begin
                    o_cmd.status = 1'b1;
                end
            end
            MODE_CURSOR: begin
                n_cur_col = i_xpos;
                n_cur_row = i_ypos;
            end
            MODE_READ: begin
                if (w_x_ok && w_y_ok) begin
                    o_cmd.op   = OP_READ;
                    o_cmd.addr = f_addr(10'(i_xpos), 9'(i_ypos));
                end else begin
                    o_cmd.status = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (o_push) begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
        end
    end

endmodule

`default_nettype wire

/* sv/mpfd_queue.sv */
// Short command queue that decouples the front end from the back end.
// Depends on mpfd_pkg.
`default_nettype none

module mpfd_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  mpfd_pkg::t_cmd       i_cmd,
    input  wire                  i_pop,
    output mpfd_pkg::t_cmd       o_head,
    output mpfd_pkg::t_qstat     o_stat
);
    import mpfd_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_head       = r_slot[r_rp];
    assign o_stat.full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= f_next(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_next(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* sv/mpfd_back.sv */
// Back end: owns the frame store memory and carries out commands from the queue.
// Depends on mpfd_pkg.
`default_nettype none

module mpfd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mpfd_pkg::t_qstat     i_qstat,
    input  mpfd_pkg::t_cmd       i_head,
    output logic                 o_pop,
    output logic                 o_clearing,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic                 o_status,
    output logic [7:0]           o_read_data
);
    import mpfd_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DRAW  = 6'b000100,
        S_FILL  = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    logic [7:0]           r_mem [STORE_BYTES];
    logic [7:0]           r_mem_q;
    t_state               r_state;
    t_state               n_state;
    t_cmd                 r_cmd;
    logic [ADDR_W-1:0]    r_sweep;
    logic [COL_IDX_W-1:0] r_idx;
    logic [COL_IDX_W-1:0] r_pidx;
    logic                 r_rd_done;
    logic                 r_pend;
    logic                 r_out_vld;
    logic                 r_status;
    logic [7:0]           r_rdata;
    logic                 w_re;
    logic [ADDR_W-1:0]    w_raddr;
    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [7:0]           w_wdata;
    logic [7:0]           w_mask;
    logic                 w_load;

    assign w_mask = 8'b1 << r_cmd.bitsel;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_re    = 1'b0;
        w_raddr = r_cmd.addr + ADDR_W'(r_idx);
        w_we    = 1'b0;
        w_waddr = r_sweep;
        w_wdata = '0;
        w_load  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                if (r_sweep == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    case (i_head.op)
                        OP_DRAW: n_state = S_DRAW;
                        OP_FILL: n_state = S_FILL;
                        OP_READ: n_state = S_READ;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DRAW: begin
                // Reads run one column ahead of the read-modify-write.
                w_re    = !r_rd_done;
                w_we    = r_pend && r_cmd.wen[r_pidx];
                w_waddr = r_cmd.addr + ADDR_W'(r_pidx);
                w_wdata = r_cmd.wval[r_pidx] ? (r_mem_q | w_mask) : (r_mem_q & ~w_mask);
                if (r_rd_done && r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_wdata = {8{r_cmd.wval[0]}};
                if (r_sweep == LAST_ADDR) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                w_re    = 1'b1;
                w_raddr = r_cmd.addr;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_mem_q <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (r_state == S_DRAW && !r_rd_done) begin
            r_pidx <= r_idx;
        end
        if (w_load) begin
            r_status <= r_cmd.status;
            r_rdata  <= (r_cmd.op == OP_READ) ? r_mem_q : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_sweep   <= '0;
            r_idx     <= '0;
            r_rd_done <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR || r_state == S_FILL) begin
                r_sweep <= (r_sweep == LAST_ADDR) ? '0 : r_sweep + ADDR_W'(1);
            end
            if (o_pop) begin
                r_idx     <= '0;
                r_rd_done <= 1'b0;
                r_pend    <= 1'b0;
            end else if (r_state == S_DRAW) begin
                r_pend <= !r_rd_done;
                if (!r_rd_done) begin
                    if (r_idx == r_cmd.last_col) begin
                        r_rd_done <= 1'b1;
                    end else begin
                        r_idx <= r_idx + COL_IDX_W'(1);
                    end
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_clearing  = r_state == S_CLEAR;
    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;
    assign o_read_data = r_rdata;

endmodule

`default_nettype wire

/* sv/mono_page_framebuffer_draw.sv */
// Monochrome page-layout frame buffer with drawing commands; top level over mpfd_pkg.
// Throughput is set by the single frame store port pair: one column read-modify-write
// per cycle while a draw runs. Reset is synchronous and active low; afterwards a
// clearing pass blanks the store.
`default_nettype none

module mono_page_framebuffer_draw (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // Configuration port.
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [mpfd_pkg::PADDR_W-1:0]   paddr,
    input  wire [mpfd_pkg::PDATA_W-1:0]   pwdata,
    output logic [mpfd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // Item channel.
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire [2:0]                     i_mode,
    input  wire [7:0]                     i_xpos,
    input  wire [7:0]                     i_ypos,
    input  wire                           i_color,
    input  wire [15:0]                    i_pattern,
    input  wire [4:0]                     i_span_count,
    input  wire [3:0]                     i_glyph_row,
    input  wire                           i_last,
    // Result channel.
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic                          o_status,
    output logic [7:0]                    o_read_data
);
    import mpfd_pkg::*;

    // The front end classifies every transfer at once: it applies the cursor, the fit
    // checks and the color inversion, so the back end never looks at configuration.
    // Commands wait in a two-entry queue; the back end walks the columns of a draw with
    // the read of one column overlapping the write of the one before.

    t_cfg   w_cfg;
    t_qstat w_qstat;
    t_cmd   w_push_cmd;
    t_cmd   w_head;
    logic   w_push;
    logic   w_pop;
    logic   w_clearing;

    mpfd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    mpfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_qstat      (w_qstat),
        .i_clearing   (w_clearing),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_xpos       (i_xpos),
        .i_ypos       (i_ypos),
        .i_color      (i_color),
        .i_pattern    (i_pattern),
        .i_span_count (i_span_count),
        .i_glyph_row  (i_glyph_row),
        .i_last       (i_last),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    mpfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    // The back end also owns the clearing pass, during which no transfer is taken.
    mpfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_read_data (o_read_data)
    );

    // The clearing pass must hold off items right after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("item channel ready during clearing pass");

    // The back end only takes a command that is in the queue.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("command taken from an empty queue");

    // A refused or dropped result never carries store data.
    a_status_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_read_data == 8'h00))
        else $error("read data on a flagged result");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for mono_page_framebuffer_draw: directed and random drawing traffic.
// Depends on mpfd_pkg and the block's RTL only; it keeps its own copy of the frame store.
`timescale 1ns / 1ps

module testbench;
    import mpfd_pkg::*;

    // The slowest item is a fill, which sweeps the whole store. The limit lies beyond
    // the whole run even with stalls, so it only trips on a hang.
    localparam int CYCLE_LIMIT   = 600000;
    // Settling time after the last result, sized to cover a full fill pass.
    localparam int SETTLE_CYCLES = 1100;
    localparam int PHASE_ITEMS   = 300;
    localparam int IDLE_PERCENT  = 7;

    // Modes 6 and 7 are not decoded by the block; they must answer a plain done status.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // One drawing command as it travels on the item channel.
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  xpos;
        logic [7:0]  ypos;
        logic        color;
        logic [15:0] pattern;
        logic [4:0]  span_count;
        logic [3:0]  glyph_row;
        logic        last;
    } t_item;

    // One answer on the result channel.
    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
    } t_result;

    // Clock, reset and every block input start at known values.
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [2:0]          in_mode    = '0;
    logic [7:0]          in_xpos    = '0;
    logic [7:0]          in_ypos    = '0;
    logic                in_color   = 1'b0;
    logic [15:0]         in_pattern = '0;
    logic [4:0]          in_count   = '0;
    logic [3:0]          in_row     = '0;
    logic                in_last    = 1'b0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic                out_status;
    logic [7:0]          out_data;

    // When set, neither the sender nor the receiver inserts idle cycles.
    logic                no_idle    = 1'b0;

    // Shadow copy of the block's state, advanced once per accepted transfer.
    logic [7:0] shadow_store [STORE_BYTES];
    logic [7:0] shadow_cursor_col;
    logic [7:0] shadow_cursor_row;
    logic       shadow_invert;
    int         shadow_glyph_w;
    int         shadow_glyph_h;

    // Answers owed by the block, oldest first.
    t_result    pending_answers [$];
    int         items_sent   = 0;
    int         answers_seen = 0;
    int         fault_count  = 0;
    int         cycle_count  = 0;

    mono_page_framebuffer_draw DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_mode       (in_mode),
        .i_xpos       (in_xpos),
        .i_ypos       (in_ypos),
        .i_color      (in_color),
        .i_pattern    (in_pattern),
        .i_span_count (in_count),
        .i_glyph_row  (in_row),
        .i_last       (in_last),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (out_status),
        .o_read_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hang guard: the run must finish long before this count is reached.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver holds off at random, except during the calm stretch.
    always @(negedge clk) begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Counts and register values above 16 behave as 16.
    function automatic int clamp16(input int value);
        return (value > 16) ? 16 : value;
    endfunction

    // Writes one pixel into the shadow store; returns 0 when it falls off the screen.
    function automatic bit plot_pixel(input int x, input int y, input logic color);
        int   idx;
        logic shade;
        if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT)
            return 1'b0;
        shade = shadow_invert ? ~color : color;
        idx   = x + (y >> 3) * SCREEN_WIDTH;
        if (shade)
            shadow_store[idx] = shadow_store[idx] | (8'h01 << (y & 7));
        else
            shadow_store[idx] = shadow_store[idx] & ~(8'h01 << (y & 7));
        return 1'b1;
    endfunction

    // Applies one command to the shadow state and returns the answer it should produce.
    function automatic t_result draw_and_answer(input t_item it);
        t_result ans;
        int      n;
        int      glyph_y;
        ans = '0;
        case (it.mode)
            MODE_PIXEL: begin
                if (!plot_pixel(it.xpos, it.ypos, it.color))
                    ans.status = 1'b1;
            end
            MODE_FILL: begin
                // Fill writes the raw color; the invert setting does not apply.
                foreach (shadow_store[k])
                    shadow_store[k] = {8{it.color}};
            end
            MODE_SPAN: begin
                // Transparent: clear pattern bits leave the store alone.
                n = clamp16(it.span_count);
                for (int i = 0; i < n; i++) begin
                    if (it.pattern[15 - i] && !plot_pixel(int'(it.xpos) + i, it.ypos, it.color))
                        ans.status = 1'b1;
                end
            end
            MODE_GLYPH: begin
                if (int'(shadow_cursor_col) + shadow_glyph_w >= SCREEN_WIDTH ||
                    int'(shadow_cursor_row) + shadow_glyph_h >= SCREEN_HEIGHT ||
                    int'(it.glyph_row) >= shadow_glyph_h) begin
                    ans.status = 1'b1;
                end else begin
                    // Opaque: every column of the glyph row is written one way or the other.
                    glyph_y = int'(shadow_cursor_row) + int'(it.glyph_row);
                    for (int i = 0; i < shadow_glyph_w; i++)
                        void'(plot_pixel(int'(shadow_cursor_col) + i, glyph_y,
                                         it.pattern[15 - i] ? it.color : ~it.color));
                    if (it.last)
                        shadow_cursor_col = 8'(int'(shadow_cursor_col) + shadow_glyph_w);
                end
            end
            MODE_CURSOR: begin
                shadow_cursor_col = it.xpos;
                shadow_cursor_row = it.ypos;
            end
            MODE_READ: begin
                if (it.xpos >= SCREEN_WIDTH || it.ypos >= SCREEN_HEIGHT)
                    ans.status = 1'b1;
                else
                    ans.read_data = shadow_store[int'(it.xpos) + (int'(it.ypos) >> 3) * SCREEN_WIDTH];
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_fault(input string msg);
        if (fault_count < 10)
            $display("%s", msg);
        fault_count++;
    endtask

    // Every accepted result is compared with the oldest pending answer.
    always @(posedge clk) begin : answer_check
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_answers.size() == 0) begin
                note_fault($sformatf("result %0d arrived with no command outstanding",
                                     answers_seen));
            end else begin
                want = pending_answers.pop_front();
                if (out_status !== want.status || out_data !== want.read_data)
                    note_fault($sformatf(
                        "result %0d mismatch: status exp %0b got %0b, read_data exp %02h got %02h",
                        answers_seen, want.status, out_status, want.read_data, out_data));
            end
            answers_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    function automatic t_item make_item(input logic [2:0] mode, input logic [7:0] x,
                                        input logic [7:0] y, input logic color,
                                        input logic [15:0] pattern, input logic [4:0] count,
                                        input logic [3:0] row, input logic last);
        t_item it;
        it.mode       = mode;
        it.xpos       = x;
        it.ypos       = y;
        it.color      = color;
        it.pattern    = pattern;
        it.span_count = count;
        it.glyph_row  = row;
        it.last       = last;
        return it;
    endfunction

    // Presents one command and waits for its transfer. Valid stays high from one
    // command to the next unless an idle gap is drawn.
    task automatic send_item(input t_item it);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end else begin
            @(negedge clk);
        end
        in_mode    <= it.mode;
        in_xpos    <= it.xpos;
        in_ypos    <= it.ypos;
        in_color   <= it.color;
        in_pattern <= it.pattern;
        in_count   <= it.span_count;
        in_row     <= it.glyph_row;
        in_last    <= it.last;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_answers.push_back(draw_and_answer(it));
        items_sent++;
    endtask

    // Drops valid and lets every outstanding answer come back.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge
    // where the access phase meets pready.
    task automatic write_reg(input t_reg which, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (which)
            REG_INVERT:  shadow_invert  = value[0];
            REG_GLYPH_W: shadow_glyph_w = clamp16(int'(value[4:0]));
            REG_GLYPH_H: shadow_glyph_h = clamp16(int'(value[4:0]));
            default: begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Places the cursor (usually where a glyph fits) and writes one to three glyphs
    // row by row, so the fit check, the row check and the cursor advance are all
    // exercised with real content. A few rows carry a stray row index or end flag.
    task automatic write_glyph_text();
        int          glyphs;
        logic        color;
        logic [3:0]  row_idx;
        logic        row_last;
        if ($urandom_range(0, 9) == 0)
            send_item(make_item(MODE_CURSOR, 8'($urandom), 8'($urandom), 1'b0, 16'h0000,
                                5'd0, 4'd0, 1'b0));
        else
            send_item(make_item(MODE_CURSOR,
                                8'($urandom_range(0, SCREEN_WIDTH - 1 - shadow_glyph_w)),
                                8'($urandom_range(0, SCREEN_HEIGHT - 1 - shadow_glyph_h)),
                                1'b0, 16'h0000, 5'd0, 4'd0, 1'b0));
        glyphs = $urandom_range(1, 3);
        repeat (glyphs) begin
            color = 1'($urandom);
            for (int r = 0; r < shadow_glyph_h; r++) begin
                row_idx  = 4'(r);
                row_last = (r == shadow_glyph_h - 1);
                if ($urandom_range(0, 19) == 0)
                    row_idx = 4'($urandom);
                if ($urandom_range(0, 19) == 0)
                    row_last = ~row_last;
                // Position and count fields are ignored in this mode, so they stay random.
                send_item(make_item(MODE_GLYPH, 8'($urandom), 8'($urandom), color,
                                    16'($urandom), 5'($urandom), row_idx, row_last));
            end
        end
    endtask

    // Random traffic weighted toward on-screen drawing and read-back, with fills kept
    // rare because each one occupies the block for a whole store pass.
    task automatic run_random_mix(input int count);
        int    stop_at;
        int    pick;
        t_item it;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            // Start from a fully random command; the categories below refine it.
            it = make_item(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                           16'($urandom), 5'($urandom), 4'($urandom), 1'($urandom));
            if (pick < 20) begin
                it.mode = MODE_PIXEL;
                if ($urandom_range(0, 9) != 0) begin
                    it.xpos = 8'($urandom_range(0, SCREEN_WIDTH - 1));
                    it.ypos = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
                end
            end else if (pick < 35) begin
                it.mode = MODE_SPAN;
                if ($urandom_range(0, 9) != 0) begin
                    it.xpos       = 8'($urandom_range(0, SCREEN_WIDTH - 1));
                    it.ypos       = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
                    it.span_count = 5'($urandom_range(0, 16));
                end
            end else if (pick < 55) begin
                it.mode = MODE_GLYPH;
            end else if (pick < 78) begin
                it.mode = MODE_READ;
                if ($urandom_range(0, 9) != 0) begin
                    it.xpos = 8'($urandom_range(0, SCREEN_WIDTH - 1));
                    it.ypos = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
                end
            end else if (pick < 79) begin
                it.mode = MODE_FILL;
            end else if (pick < 82) begin
                it.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
            end else if (pick < 87) begin
                it.mode = MODE_CURSOR;
            end
            // The rest goes out as drawn: pure noise over all eight modes.
            if (pick >= 35 && pick < 55)
                write_glyph_text();
            else
                send_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner pixels land; anything past the right or bottom edge is dropped.
    task automatic test_pixel_bounds();
        send_item(make_item(MODE_PIXEL, 8'd0,   8'd0,   1'b1, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_PIXEL, 8'd127, 8'd63,  1'b1, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_PIXEL, 8'd128, 8'd0,   1'b1, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_PIXEL, 8'd0,   8'd64,  1'b1, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_PIXEL, 8'd255, 8'd255, 1'b1, 16'hFFFF, 5'd31, 4'd15, 1'b1));
        send_item(make_item(MODE_READ,  8'd0,   8'd0,   1'b0, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_READ,  8'd127, 8'd63,  1'b0, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_READ,  8'd128, 8'd0,   1'b0, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_READ,  8'd5,   8'd200, 1'b0, 16'h0000, 5'd0, 4'd0, 1'b0));
    endtask

    // A span running off the right edge, an oversized count, and a zero count.
    task automatic test_span_edges();
        send_item(make_item(MODE_SPAN, 8'd120, 8'd5,  1'b1, 16'hFFFF, 5'd16, 4'd0, 1'b1));
        send_item(make_item(MODE_SPAN, 8'd0,   8'd10, 1'b1, 16'h8001, 5'd31, 4'd0, 1'b0));
        send_item(make_item(MODE_SPAN, 8'd0,   8'd0,  1'b0, 16'hFFFF, 5'd0,  4'd0, 1'b0));
        send_item(make_item(MODE_READ, 8'd15,  8'd10, 1'b0, 16'h0000, 5'd0,  4'd0, 1'b0));
    endtask

    // Glyph rows at the default 7x10 size: a good row, a row past the glyph height,
    // the final row that advances the cursor, and both ways of not fitting.
    task automatic test_glyph_rules();
        send_item(make_item(MODE_CURSOR, 8'd0,   8'd0,  1'b0, 16'h0000, 5'd0, 4'd0,  1'b0));
        send_item(make_item(MODE_GLYPH,  8'd0,   8'd0,  1'b1, 16'hAAAA, 5'd0, 4'd0,  1'b0));
        send_item(make_item(MODE_GLYPH,  8'd0,   8'd0,  1'b1, 16'hFFFF, 5'd0, 4'd12, 1'b1));
        send_item(make_item(MODE_GLYPH,  8'd0,   8'd0,  1'b0, 16'h5555, 5'd0, 4'd9,  1'b1));
        send_item(make_item(MODE_CURSOR, 8'd121, 8'd0,  1'b0, 16'h0000, 5'd0, 4'd0,  1'b0));
        send_item(make_item(MODE_GLYPH,  8'd0,   8'd0,  1'b1, 16'hFFFF, 5'd0, 4'd0,  1'b0));
        send_item(make_item(MODE_CURSOR, 8'd0,   8'd54, 1'b0, 16'h0000, 5'd0, 4'd0,  1'b0));
        send_item(make_item(MODE_GLYPH,  8'd0,   8'd0,  1'b1, 16'hFFFF, 5'd0, 4'd0,  1'b0));
    endtask

    task automatic test_fill_and_read();
        send_item(make_item(MODE_FILL, 8'd0,  8'd0,  1'b1, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_READ, 8'd64, 8'd32, 1'b0, 16'h0000, 5'd0, 4'd0, 1'b0));
        send_item(make_item(MODE_FILL, 8'd0,  8'd0,  1'b0, 16'h0000, 5'd0, 4'd0, 1'b0));
    endtask

    task automatic test_spare_modes();
        send_item(make_item(MODE_SPARE_LO, 8'd3, 8'd3, 1'b1, 16'hFFFF, 5'd16, 4'd1, 1'b1));
        send_item(make_item(MODE_SPARE_HI, 8'd3, 8'd3, 1'b1, 16'hFFFF, 5'd16, 4'd1, 1'b1));
    endtask

    // Random traffic at the settings that reset leaves behind.
    task automatic test_reset_settings();
        run_random_mix(PHASE_ITEMS);
    endtask

    // Reprograms all three registers with the block idle, then runs random traffic.
    task automatic test_register_setting(input logic invert, input int width,
                                         input int height, input logic calm);
        wait_idle();
        write_reg(REG_INVERT,  PDATA_W'(invert));
        write_reg(REG_GLYPH_W, PDATA_W'(width));
        write_reg(REG_GLYPH_H, PDATA_W'(height));
        no_idle = calm;
        run_random_mix(PHASE_ITEMS);
        no_idle = 1'b0;
    endtask

    initial begin
        foreach (shadow_store[k])
            shadow_store[k] = 8'h00;
        shadow_cursor_col = 8'd0;
        shadow_cursor_row = 8'd0;
        shadow_invert     = 1'b0;
        shadow_glyph_w    = int'(GLYPH_W_RESET);
        shadow_glyph_h    = int'(GLYPH_H_RESET);

        // Synchronous reset is held first; the store clearing pass that follows
        // is absorbed by the ready handshake.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_pixel_bounds();
        test_span_edges();
        test_glyph_rules();
        test_fill_and_read();
        test_spare_modes();
        test_reset_settings();
        // Largest glyphs with inverted colors.
        test_register_setting(1'b1, 16, 16, 1'b0);
        // Smallest glyphs, and the stretch with no idling on either side.
        test_register_setting(1'b0, 1, 1, 1'b1);
        // Oversized register values that must saturate to 16.
        test_register_setting(1'b1, 25, 31, 1'b0);
        test_register_setting(1'($urandom), $urandom_range(1, 16), $urandom_range(1, 16), 1'b0);

        // Let the last answers drain, then watch for stray results.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
sv/mpfd_pkg.sv
sv/mpfd_regs.sv
sv/mpfd_front.sv
sv/mpfd_queue.sv
sv/mpfd_back.sv
sv/mono_page_framebuffer_draw.sv
bench/testbench.sv
